// File: rtl/rdcf_pkg.sv
// Package for the remote drive command failsafe unit.
// Transaction structs, constants and shared helpers; no dependencies.
package rdcf_pkg;

    localparam int WINDOW_DEPTH_DEF = 64;
    localparam int WINDOW_MS_DEF    = 1000;
    localparam int GAP_MS_DEF       = 100;
    localparam int GAP_LIMIT_DEF    = 5;

    localparam logic [7:0]  RAW_CENTRE     = 8'd100;
    localparam logic [15:0] RAW_TOP        = 16'd200;
    localparam logic [14:0] FAILSAFE_BRAKE = 15'd30000;
    localparam logic [7:0]  SLOW_SPEED     = 8'd10;
    localparam logic [7:0]  TOP_GEAR       = 8'd4;
    localparam logic [7:0]  MODE_REMOTE    = 8'd4;
    localparam logic [7:0]  MODE_ASSIST    = 8'd2;

    localparam logic [1:0] REG_SPEED_CAP  = 2'd0;
    localparam logic [1:0] REG_TIMEOUT_MS = 2'd1;
    localparam logic [1:0] REG_RECOVER_MS = 2'd2;

    localparam logic ACT_FRAME = 1'b0;
    localparam logic ACT_CHECK = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] now_ms;
        logic [7:0]  control_mode;
        logic [15:0] throttle_brake;
        logic [7:0]  steering_raw;
        logic [7:0]  gear_request;
        logic [7:0]  heartbeat;
        logic [7:0]  speed_request;
    } rdcf_in_t;

    typedef struct packed {
        logic               remote_enable;
        logic               assist_enable;
        logic [2:0]         gear_out;
        logic [7:0]         speed_limit_out;
        logic [14:0]        accel_out;
        logic [14:0]        brake_out;
        logic signed [15:0] steer_out;
        logic [7:0]         heartbeat_out;
        logic               timeout_fault;
        logic               delay_fault;
        logic               changed;
    } rdcf_out_t;

    // x * 32767 / 100 for x in 0..100, truncated; 327.67 as a fixed point multiplier
    // with 14 fraction bits, exact over the whole input range
    function automatic logic [14:0] scale_full(input logic [6:0] x);
        logic [29:0] p;
        begin
            p = 30'(x) * 30'd5368546;
            scale_full = p[28:14];
        end
    endfunction

endpackage

// File: rtl/rdcf_window.sv
// Gap window memory with an iterative scan unit for the failsafe unit.
// Depends on rdcf_pkg.
module rdcf_window
    import rdcf_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int WINDOW_MS    = WINDOW_MS_DEF,
    parameter int GAP_MS       = GAP_MS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        clear,
    input  logic        start,
    input  logic [31:0] beat_time,
    output logic        done,
    output logic [5:0]  gaps
);
    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);

    typedef enum logic [2:0] {S_IDLE, S_AGE_RD, S_AGE, S_SCAN_RD, S_SCAN, S_DONE} st_t;

    logic [31:0] mem [WINDOW_DEPTH];
    logic [31:0] rd_data_reg;
    logic [AW-1:0] head_reg, rd_addr;
    logic [CW-1:0] count_reg, idx_reg;
    logic [31:0] prev_reg;
    logic [5:0]  gaps_reg;
    st_t state_reg;
    logic rd_en;

    // all callers pass values below 2*WINDOW_DEPTH
    function automatic logic [AW-1:0] wrap(input logic [CW:0] v);
        wrap = (v >= (CW+1)'(WINDOW_DEPTH)) ? AW'(v - (CW+1)'(WINDOW_DEPTH)) : AW'(v);
    endfunction

    always_comb
    begin
        rd_en   = (state_reg == S_AGE_RD) || (state_reg == S_SCAN_RD);
        rd_addr = (state_reg == S_AGE_RD) ? head_reg
                : wrap({1'b0, CW'(head_reg)} + {1'b0, idx_reg});
    end

    // a full window overwrites the oldest entry, at head
    always_ff @(posedge clk)
    begin
        if (start && state_reg == S_IDLE && !clear)
            mem[wrap({1'b0, CW'(head_reg)} + {1'b0, count_reg})] <= beat_time;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
            gaps_reg  <= '0;
            prev_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (clear)
                    begin
                        head_reg  <= '0;
                        count_reg <= '0;
                    end
                    else if (start)
                    begin
                        if (count_reg >= CW'(WINDOW_DEPTH))
                            head_reg <= wrap({1'b0, CW'(head_reg)} + 1'b1);
                        else
                            count_reg <= count_reg + 1'b1;
                        gaps_reg  <= '0;
                        state_reg <= S_AGE_RD;
                    end
                end
                S_AGE_RD:
                    state_reg <= (count_reg == '0) ? S_SCAN_RD : S_AGE;
                S_AGE:
                begin
                    if (beat_time - rd_data_reg > 32'(WINDOW_MS))
                    begin
                        head_reg  <= wrap({1'b0, CW'(head_reg)} + 1'b1);
                        count_reg <= count_reg - 1'b1;
                        state_reg <= S_AGE_RD;
                    end
                    else
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD:
                    state_reg <= (idx_reg >= count_reg) ? S_DONE : S_SCAN;
                S_SCAN:
                begin
                    if (idx_reg != '0 && rd_data_reg - prev_reg > 32'(GAP_MS)
                        && gaps_reg != 6'h3f)
                        gaps_reg <= gaps_reg + 1'b1;
                    prev_reg  <= rd_data_reg;
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_SCAN_RD;
                end
                S_DONE:
                begin
                    if (clear)
                    begin
                        head_reg  <= '0;
                        count_reg <= '0;
                    end
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign done = (state_reg == S_DONE);
    assign gaps = gaps_reg;
endmodule

// File: rtl/remote_drive_command_failsafe_unit.sv
// Top level of the remote drive command failsafe unit: sequencer and command state.
// Depends on rdcf_pkg and rdcf_window.
//
// Usage: items arrive on in_valid/in_ready as rdcf_in_t; one result per
// transaction leaves on out_valid/out_ready as rdcf_out_t. Registers are
// written on cfg_valid/cfg_ready (index 0 speed_cap, 1 timeout_ms,
// 2 recover_ms); other indexes are ignored.
// A command frame, or a check with remote disabled, goes through S_FRAME or
// S_CHECK to S_OUT. A supervision check with remote enabled then walks the gap
// window in rdcf_window one entry at a time: push the beat time, age out stale
// entries, count gaps. in_ready is low while an item is in work or its result
// is unread; the next item can be taken in the cycle after the result leaves.
// Reset clears all command state and fault flags, empties the window and
// loads the register defaults. A stalled receiver holds the result
// register and blocks new items; nothing is lost.
module remote_drive_command_failsafe_unit
    import rdcf_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int WINDOW_MS    = WINDOW_MS_DEF,
    parameter int GAP_MS       = GAP_MS_DEF,
    parameter int GAP_LIMIT    = GAP_LIMIT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  rdcf_in_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output rdcf_out_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    typedef enum logic [2:0] {S_IDLE, S_FRAME, S_CHECK, S_WAIT, S_GAPS, S_OUT} st_t;

    st_t state_reg;
    rdcf_in_t in_reg;
    logic [7:0]  speed_cap_reg;
    logic [15:0] timeout_ms_reg, recover_ms_reg;
    logic remote_reg, assist_reg, changed_reg, tfault_reg, dfault_reg;
    logic [2:0]  gear_reg;
    logic [7:0]  speed_reg, beat_reg;
    logic [14:0] accel_reg, brake_reg;
    logic signed [15:0] steer_reg;
    logic [31:0] beat_time_reg, trec_reg, drec_reg;
    logic [12:0] snap_reg;

    logic win_clear, win_start, win_done;
    logic [5:0] win_gaps;

    rdcf_window #(
        .WINDOW_DEPTH(WINDOW_DEPTH),
        .WINDOW_MS(WINDOW_MS),
        .GAP_MS(GAP_MS)
    ) u_window (
        .clk(clk),
        .rst_n(rst_n),
        .clear(win_clear),
        .start(win_start),
        .beat_time(beat_time_reg),
        .done(win_done),
        .gaps(win_gaps)
    );

    // frame datapath
    logic off, f_remote, f_assist;
    logic [15:0] tb_c;
    logic signed [8:0] centre;
    logic [6:0] mag;
    logic [14:0] steer_mag;
    logic [2:0] f_gear;
    logic [7:0] f_speed;
    logic [14:0] f_accel, f_brake;
    logic [12:0] f_snap;
    logic timed_out;

    always_comb
    begin
        off      = (in_reg.throttle_brake != 16'(RAW_CENTRE)) || (in_reg.steering_raw != RAW_CENTRE);
        f_remote = (in_reg.control_mode == MODE_REMOTE || in_reg.control_mode == MODE_ASSIST) && off;
        f_assist = (in_reg.control_mode == MODE_ASSIST) && off;
        tb_c     = (in_reg.throttle_brake > RAW_TOP) ? RAW_TOP : in_reg.throttle_brake;
        centre   = $signed({1'b0, RAW_CENTRE}) - $signed({1'b0, in_reg.steering_raw});
        if (centre < -9'sd100)
            centre = -9'sd100;
        mag       = centre[8] ? 7'(-centre) : 7'(centre);
        steer_mag = scale_full(mag);
        f_accel   = '0;
        f_brake   = '0;
        if (tb_c > 16'(RAW_CENTRE))
            f_accel = scale_full(7'(tb_c - 16'(RAW_CENTRE)));
        else if (tb_c < 16'(RAW_CENTRE))
            f_brake = scale_full(7'(16'(RAW_CENTRE) - tb_c));
        f_gear  = (in_reg.gear_request > TOP_GEAR) ? 3'd0 : in_reg.gear_request[2:0];
        f_speed = (in_reg.speed_request > speed_cap_reg) ? speed_cap_reg : in_reg.speed_request;
        f_snap  = {f_speed, f_assist, f_remote, f_gear};
        timed_out = (in_reg.now_ms - beat_time_reg) > {16'd0, timeout_ms_reg};
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = (state_reg == S_OUT);
    assign win_start = (state_reg == S_WAIT);
    // empty the window on a timeout before the push, and after a delay fault
    assign win_clear = ((state_reg == S_CHECK) && remote_reg && timed_out)
                     || ((state_reg == S_GAPS) && win_done && (win_gaps >= 6'(GAP_LIMIT)));

    always_comb
    begin
        out_data.remote_enable   = remote_reg;
        out_data.assist_enable   = assist_reg;
        out_data.gear_out        = gear_reg;
        out_data.speed_limit_out = speed_reg;
        out_data.accel_out       = accel_reg;
        out_data.brake_out       = brake_reg;
        out_data.steer_out       = steer_reg;
        out_data.heartbeat_out   = beat_reg;
        out_data.timeout_fault   = tfault_reg;
        out_data.delay_fault     = dfault_reg;
        out_data.changed         = changed_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_reg <= in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            speed_cap_reg  <= 8'd30;
            timeout_ms_reg <= 16'd500;
            recover_ms_reg <= 16'd3000;
            remote_reg     <= 1'b0;
            assist_reg     <= 1'b0;
            changed_reg    <= 1'b0;
            tfault_reg     <= 1'b0;
            dfault_reg     <= 1'b0;
            gear_reg       <= '0;
            speed_reg      <= '0;
            beat_reg       <= '0;
            accel_reg      <= '0;
            brake_reg      <= '0;
            steer_reg      <= '0;
            beat_time_reg  <= '0;
            trec_reg       <= '0;
            drec_reg       <= '0;
            snap_reg       <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_SPEED_CAP:  speed_cap_reg  <= cfg_data[7:0];
                    REG_TIMEOUT_MS: timeout_ms_reg <= cfg_data;
                    REG_RECOVER_MS: recover_ms_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                    if (in_valid)
                        state_reg <= (in_data.action == ACT_FRAME) ? S_FRAME : S_CHECK;
                S_FRAME:
                begin
                    remote_reg  <= f_remote;
                    assist_reg  <= f_assist;
                    steer_reg   <= centre[8] ? $signed({1'b0, steer_mag})
                                             : -$signed({1'b0, steer_mag});
                    accel_reg   <= f_accel;
                    brake_reg   <= f_brake;
                    gear_reg    <= f_gear;
                    speed_reg   <= f_speed;
                    if (beat_reg != in_reg.heartbeat)
                    begin
                        beat_reg      <= in_reg.heartbeat;
                        beat_time_reg <= in_reg.now_ms;
                    end
                    changed_reg <= (f_snap != snap_reg);
                    snap_reg    <= f_snap;
                    state_reg   <= S_OUT;
                end
                S_CHECK:
                begin
                    changed_reg <= 1'b0;
                    if (!remote_reg)
                    begin
                        if (tfault_reg)
                            brake_reg <= '0;
                        tfault_reg <= 1'b0;
                        dfault_reg <= 1'b0;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        if (timed_out)
                        begin
                            accel_reg  <= '0;
                            brake_reg  <= FAILSAFE_BRAKE;
                            tfault_reg <= 1'b1;
                            trec_reg   <= '0;
                        end
                        else if (trec_reg == '0)
                            trec_reg <= in_reg.now_ms;
                        else if (in_reg.now_ms - trec_reg >= {16'd0, recover_ms_reg})
                        begin
                            if (tfault_reg)
                            begin
                                tfault_reg <= 1'b0;
                                brake_reg  <= '0;
                            end
                            trec_reg <= '0;
                        end
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                    state_reg <= S_GAPS;
                S_GAPS:
                    if (win_done)
                    begin
                        if (win_gaps >= 6'(GAP_LIMIT))
                        begin
                            if (speed_reg > SLOW_SPEED)
                                speed_reg <= SLOW_SPEED;
                            dfault_reg <= 1'b1;
                            drec_reg   <= '0;
                        end
                        else if (win_gaps != '0)
                            drec_reg <= '0;
                        else if (drec_reg == '0)
                            drec_reg <= in_reg.now_ms;
                        else if (in_reg.now_ms - drec_reg >= {16'd0, recover_ms_reg})
                        begin
                            dfault_reg <= 1'b0;
                            drec_reg   <= '0;
                        end
                        state_reg <= S_OUT;
                    end
                S_OUT:
                    if (out_ready)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
